@@ hw/rtl/cdt_pkg.sv @@
// ---------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the countdown timer controller
// Beat formats, mode and event codes, register indexes and the constants of
// the divide-by-sixty used to split a time value into minutes and seconds.
// ---------------------------------------------------------------------------
package cdt_pkg;

	localparam int TIME_BITS  = 16;
	localparam int TOTAL_BITS = 24;
	localparam int SHOW_BITS  = (TIME_BITS > TOTAL_BITS) ? TIME_BITS : TOTAL_BITS;

	localparam int CMD_W     = 3;
	localparam int PHASE_W   = 4;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int MINUTES_W = 19;
	localparam int SECONDS_W = 6;
	localparam int MSG_W     = 2;
	localparam int STEP_W    = 8;
	localparam int HOLD_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// floor(t / 60) = (t * DIV60_RECIP) >> DIV60_SHIFT, exact for t < 2^SHOW_BITS
	localparam int DIV60_SHIFT = SHOW_BITS + 6;
	localparam int RECIP_BITS  = SHOW_BITS + 1;
	localparam int PROD_BITS   = SHOW_BITS + RECIP_BITS;
	localparam int QUOT_BITS   = SHOW_BITS - 5;
	localparam logic [RECIP_BITS-1:0] DIV60_RECIP =
		RECIP_BITS'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);

	// event codes
	localparam logic [CMD_W-1:0] CMD_INC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ABORT = 3'd4;

	// reported mode codes
	localparam logic [MODE_W-1:0] MODE_CODE_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_SET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_RUN   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CODE_PAUSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CODE_STAT  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_HANDLED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TRANS   = 2'd2;

	localparam logic [MSG_W-1:0] MSG_NONE       = 2'd0;
	localparam logic [MSG_W-1:0] MSG_SET_TIME   = 2'd1;
	localparam logic [MSG_W-1:0] MSG_PAUSED     = 2'd2;
	localparam logic [MSG_W-1:0] MSG_PRODUCTIVE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SECONDS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_PHASE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_PHASE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_HOLD_TICKS = 2'd3;

	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_SET   = 5'b00010,
		MODE_RUN   = 5'b00100,
		MODE_PAUSE = 5'b01000,
		MODE_STAT  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [PHASE_W-1:0] sub_tick;
	} in_t;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [STATUS_W-1:0]  status;
		logic                 beep;
		logic                 show_time;
		logic [MINUTES_W-1:0] minutes;
		logic [SECONDS_W-1:0] seconds;
		logic [MSG_W-1:0]     message;
		logic                 clear_display;
	} out_t;

	function automatic logic [MODE_W-1:0] mode_code(mode_t m);
		logic [MODE_W-1:0] c;
		unique case (m)
			MODE_IDLE:  c = MODE_CODE_IDLE;
			MODE_SET:   c = MODE_CODE_SET;
			MODE_RUN:   c = MODE_CODE_RUN;
			MODE_PAUSE: c = MODE_CODE_PAUSE;
			MODE_STAT:  c = MODE_CODE_STAT;
			default:    c = MODE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/countdown_timer_controller.sv @@
// ---------------------------------------------------------------------------
// countdown_timer_controller: five-mode countdown timer
// Idle, time set, countdown, pause and statistics modes driven by button and
// tick events, with saturating set, elapsed and productive time counters.
// ---------------------------------------------------------------------------
// The block takes one event beat per clock cycle and returns one result beat
// per event, in order. A beat passes through the input register, the
// mode update (which reads and writes the timer state as the beat leaves the
// input register, so back-to-back events see each other's effect), the
// multiply by the reciprocal of sixty, and the remainder step feeding the
// output register. When out_stall is held the pipeline fills and then stalls
// the input; otherwise one event is taken every cycle. Configuration registers
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while no event is in flight, as the block does not enforce this.
module countdown_timer_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  cdt_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output cdt_pkg::out_t             out_data
);
	import cdt_pkg::*;

	localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
	localparam logic [SHOW_BITS:0]    TOTAL_MAX_W = (SHOW_BITS+1)'({TOTAL_BITS{1'b1}});

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [STATUS_W-1:0] status;
		logic                beep;
		logic                show_time;
		logic [MSG_W-1:0]    message;
		logic                clear_display;
	} flags_t;

	// configuration
	logic [STEP_W-1:0]  step_seconds_q;
	logic [PHASE_W-1:0] beep_phase_q;
	logic [PHASE_W-1:0] second_phase_q;
	logic [HOLD_W-1:0]  stat_hold_ticks_q;

	// timer state
	mode_t                 mode_q;
	logic [TIME_BITS-1:0]  set_time_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [HOLD_W-1:0]     stat_ticks_q;

	// pipeline
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ld1, ld2, ld3, ld4;
	in_t                  item_s1;
	flags_t               flags_s2, flags_s3;
	logic [SHOW_BITS-1:0] val_s2, val_s3;
	logic [QUOT_BITS-1:0] quot_s3;
	out_t                 res_s4;

	// mode update logic
	mode_t                 mode_n;
	logic [TIME_BITS-1:0]  set_n;
	logic [TIME_BITS-1:0]  el_n;
	logic [TOTAL_BITS-1:0] tot_n;
	logic [HOLD_W-1:0]     st_n;
	flags_t                flags_n;
	logic [SHOW_BITS-1:0]  val_n;
	logic                  enough;
	logic [TIME_BITS:0]    set_sum;
	logic [TIME_BITS-1:0]  set_inc;
	logic [TIME_BITS-1:0]  set_dec;
	logic [TIME_BITS-1:0]  set_cnt;
	logic [TIME_BITS-1:0]  el_inc;
	logic [SHOW_BITS:0]    tot_sum;
	logic [HOLD_W-1:0]     st_inc;
	logic                  tick_beep;
	logic                  tick_sec;

	// divide stage
	logic [PROD_BITS-1:0] prod;
	logic [SHOW_BITS-1:0] quot_x60;
	logic [SHOW_BITS-1:0] rem;

	assign ld4 = !valid_s4 || !out_stall;
	assign ld3 = !valid_s3 || ld4;
	assign ld2 = !valid_s2 || ld3;
	assign ld1 = !valid_s1 || ld2;

	assign in_stall  = !ld1;
	assign out_valid = valid_s4;
	assign out_data  = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_seconds_q    <= STEP_W'(60);
			beep_phase_q      <= PHASE_W'(5);
			second_phase_q    <= PHASE_W'(10);
			stat_hold_ticks_q <= HOLD_W'(30);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_SECONDS:    step_seconds_q    <= cfg_data[STEP_W-1:0];
				REG_BEEP_PHASE:      beep_phase_q      <= cfg_data[PHASE_W-1:0];
				REG_SECOND_PHASE:    second_phase_q    <= cfg_data[PHASE_W-1:0];
				REG_STAT_HOLD_TICKS: stat_hold_ticks_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		enough    = set_time_q >= TIME_BITS'(step_seconds_q);
		set_sum   = (TIME_BITS+1)'(set_time_q) + (TIME_BITS+1)'(step_seconds_q);
		set_inc   = set_sum[TIME_BITS] ? TIME_MAX : set_sum[TIME_BITS-1:0];
		set_dec   = set_time_q - TIME_BITS'(step_seconds_q);
		set_cnt   = (set_time_q != '0) ? set_time_q - TIME_BITS'(1) : '0;
		el_inc    = (elapsed_q == TIME_MAX) ? TIME_MAX : elapsed_q + TIME_BITS'(1);
		st_inc    = stat_ticks_q + HOLD_W'(1);
		tick_beep = (item_s1.cmd == CMD_TICK) && (item_s1.sub_tick == beep_phase_q);
		tick_sec  = (item_s1.cmd == CMD_TICK) && (item_s1.sub_tick == second_phase_q);

		mode_n  = mode_q;
		set_n   = set_time_q;
		el_n    = elapsed_q;
		tot_n   = total_q;
		st_n    = stat_ticks_q;
		val_n   = '0;
		tot_sum = '0;
		flags_n = '{mode: MODE_CODE_IDLE, status: STATUS_IGNORED, beep: 1'b0,
			show_time: 1'b0, message: MSG_NONE, clear_display: 1'b0};

		unique case (mode_q)
			MODE_IDLE: begin
				if (item_s1.cmd == CMD_INC) begin
					set_n  = set_inc;
					mode_n = MODE_SET;
				end else if (item_s1.cmd == CMD_START) begin
					mode_n = MODE_STAT;
				end else if (tick_beep) begin
					flags_n.beep   = 1'b1;
					flags_n.status = STATUS_HANDLED;
				end
			end
			MODE_SET: begin
				if (item_s1.cmd == CMD_INC) begin
					set_n = set_inc;
					val_n = SHOW_BITS'(set_inc);
					flags_n.show_time = 1'b1;
					flags_n.status    = STATUS_HANDLED;
				end else if (item_s1.cmd == CMD_DEC && enough) begin
					set_n = set_dec;
					val_n = SHOW_BITS'(set_dec);
					flags_n.show_time = 1'b1;
					flags_n.status    = STATUS_HANDLED;
				end else if (item_s1.cmd == CMD_ABORT) begin
					mode_n = MODE_IDLE;
				end else if (item_s1.cmd == CMD_START && enough && set_time_q != '0) begin
					mode_n = MODE_RUN;
				end
			end
			MODE_RUN: begin
				if (tick_sec) begin
					set_n = set_cnt;
					el_n  = el_inc;
					val_n = SHOW_BITS'(set_cnt);
					flags_n.show_time = 1'b1;
					if (set_cnt == '0) begin
						mode_n = MODE_IDLE;
					end else begin
						flags_n.status = STATUS_HANDLED;
					end
				end else if (item_s1.cmd == CMD_START) begin
					mode_n = MODE_PAUSE;
				end else if (item_s1.cmd == CMD_ABORT) begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_PAUSE: begin
				if (item_s1.cmd == CMD_INC) begin
					set_n  = set_inc;
					mode_n = MODE_SET;
				end else if (item_s1.cmd == CMD_DEC && enough) begin
					set_n  = set_dec;
					mode_n = MODE_SET;
				end else if (item_s1.cmd == CMD_START) begin
					mode_n = MODE_RUN;
				end else if (item_s1.cmd == CMD_ABORT) begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_STAT: begin
				if (item_s1.cmd == CMD_TICK) begin
					if (st_inc >= stat_hold_ticks_q) begin
						st_n   = '0;
						mode_n = MODE_IDLE;
					end else begin
						st_n = st_inc;
					end
				end
			end
			default: ;
		endcase

		if (mode_n != mode_q) begin
			flags_n.status = STATUS_TRANS;
			// exit action of the old mode
			if (mode_q == MODE_RUN) begin
				tot_sum = (SHOW_BITS+1)'(total_q) + (SHOW_BITS+1)'(el_n);
				tot_n   = (tot_sum > TOTAL_MAX_W) ? TOTAL_BITS'(TOTAL_MAX_W)
					: TOTAL_BITS'(tot_sum);
				el_n    = '0;
			end else begin
				flags_n.clear_display = 1'b1;
			end
			// entry action of the new mode
			unique case (mode_n)
				MODE_IDLE: begin
					set_n = '0;
					el_n  = '0;
					val_n = '0;
					flags_n.show_time = 1'b1;
					flags_n.message   = MSG_SET_TIME;
				end
				MODE_SET: begin
					val_n = SHOW_BITS'(set_n);
					flags_n.show_time = 1'b1;
				end
				MODE_PAUSE: flags_n.message = MSG_PAUSED;
				MODE_STAT: begin
					val_n = SHOW_BITS'(tot_n);
					flags_n.show_time = 1'b1;
					flags_n.message   = MSG_PRODUCTIVE;
				end
				default: ;
			endcase
		end

		flags_n.mode = mode_code(mode_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			set_time_q   <= '0;
			elapsed_q    <= '0;
			total_q      <= '0;
			stat_ticks_q <= '0;
		end else if (valid_s1 && ld2) begin
			mode_q       <= mode_n;
			set_time_q   <= set_n;
			elapsed_q    <= el_n;
			total_q      <= tot_n;
			stat_ticks_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ld1) begin
				valid_s1 <= in_valid;
			end
			if (ld2) begin
				valid_s2 <= valid_s1;
			end
			if (ld3) begin
				valid_s3 <= valid_s2;
			end
			if (ld4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign prod     = PROD_BITS'(val_s2) * PROD_BITS'(DIV60_RECIP);
	// q * 60 = q * 64 - q * 4
	assign quot_x60 = (SHOW_BITS'(quot_s3) << 6) - (SHOW_BITS'(quot_s3) << 2);
	assign rem      = val_s3 - quot_x60;

	always_ff @(posedge clk) begin
		if (in_valid && ld1) begin
			item_s1 <= in_data;
		end
		if (valid_s1 && ld2) begin
			flags_s2 <= flags_n;
			val_s2   <= val_n;
		end
		if (valid_s2 && ld3) begin
			flags_s3 <= flags_s2;
			val_s3   <= val_s2;
			quot_s3  <= prod[DIV60_SHIFT +: QUOT_BITS];
		end
		if (valid_s3 && ld4) begin
			res_s4.mode          <= flags_s3.mode;
			res_s4.status        <= flags_s3.status;
			res_s4.beep          <= flags_s3.beep;
			res_s4.show_time     <= flags_s3.show_time;
			res_s4.minutes       <= MINUTES_W'(quot_s3);
			res_s4.seconds       <= rem[SECONDS_W-1:0];
			res_s4.message       <= flags_s3.message;
			res_s4.clear_display <= flags_s3.clear_display;
		end
	end

endmodule
